FILE: sv/gtrle_pkg.sv
// Shared types and constants for the gray threshold run-length encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gtrle_pkg;

    // Gray weights; the products plus rounding fit 16 bits.
    localparam logic [15:0] WEIGHT_BLUE  = 16'd29;
    localparam logic [15:0] WEIGHT_GREEN = 16'd150;
    localparam logic [15:0] WEIGHT_RED   = 16'd77;
    localparam logic [15:0] GRAY_ROUND   = 16'd128;

    localparam logic [7:0] RUN_LIMIT      = 8'd255;
    localparam logic [7:0] CODE_WHITE     = 8'd255;
    localparam logic [7:0] CODE_BLACK     = 8'd0;
    localparam logic [7:0] CODE_CHANGE    = 8'd255;
    localparam logic [7:0] CODE_NO_CHANGE = 8'd0;
    localparam logic [7:0] THRESHOLD_RST  = 8'd127;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_RUN      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_first;
    } t_pixel;

    typedef struct packed {
        logic [7:0] code_byte;
        logic [1:0] byte_kind;
    } t_code;

    // What the front hands to the back for each pixel.
    typedef struct packed {
        logic [7:0] gray;
        logic       frame_first;
    } t_gray_item;

endpackage

FILE: sv/gtrle_front.sv
// Front stage: accepts pixels and registers their gray value.
// Depends on gtrle_pkg.
`timescale 1ns / 1ps

module gtrle_front import gtrle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_pixel     i_in_pixel,
    output logic       o_item_valid,
    input  logic       i_item_ready,
    output t_gray_item o_item
);

    logic       r_vld;
    t_gray_item r_item;
    logic [15:0] n_sum;

    assign n_sum = {8'd0, i_in_pixel.blue} * WEIGHT_BLUE
                 + {8'd0, i_in_pixel.green} * WEIGHT_GREEN
                 + {8'd0, i_in_pixel.red} * WEIGHT_RED
                 + GRAY_ROUND;

    assign o_in_ready   = !r_vld || i_item_ready;
    assign o_item_valid = r_vld;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.gray        <= n_sum[15:8];
            r_item.frame_first <= i_in_pixel.frame_first;
        end
    end

endmodule

FILE: sv/gtrle_queue.sv
// Short queue that decouples the gray front from the run-length back.
// Depends on gtrle_pkg.
`timescale 1ns / 1ps

module gtrle_queue import gtrle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push_valid,
    output logic       o_push_ready,
    input  t_gray_item i_push_item,
    output logic       o_pop_valid,
    input  logic       i_pop_ready,
    output t_gray_item o_pop_item
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    t_gray_item        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_FULL)
        else $error("queue count beyond depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

FILE: sv/gtrle_back.sv
// Back stage: thresholds gray values, tracks runs and holds the output code.
// Depends on gtrle_pkg.
`timescale 1ns / 1ps

module gtrle_back import gtrle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_threshold,
    input  logic       i_item_valid,
    output logic       o_item_ready,
    input  t_gray_item i_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_code      o_out_code
);

    logic       r_white;
    logic [7:0] r_run;
    logic       r_ovf;
    logic       r_out_vld;
    t_code      r_out;

    logic       n_white;
    logic [7:0] n_run;
    logic       n_ovf;
    logic       n_emit;
    t_code      n_code;
    logic       take;
    logic       first;
    logic       white_gt;
    logic       white_ge;
    logic [7:0] run_inc;

    assign o_item_ready = !r_out_vld || i_out_ready;
    assign take         = i_item_valid && o_item_ready;
    assign o_out_valid  = r_out_vld;
    assign o_out_code   = r_out;

    // A zero run count means no frame has started since reset.
    assign first    = i_item.frame_first || (r_run == 8'd0);
    assign white_gt = (i_item.gray > i_threshold);
    assign white_ge = (i_item.gray >= i_threshold);
    assign run_inc  = r_run + 8'd1;

    always_comb begin
        n_white = r_white;
        n_run   = r_run;
        n_ovf   = r_ovf;
        n_emit  = 1'b0;
        n_code  = '{code_byte: CODE_BLACK, byte_kind: KIND_START};
        if (first) begin
            n_white = white_gt;
            n_run   = 8'd1;
            n_ovf   = 1'b0;
            n_emit  = 1'b1;
            n_code  = '{code_byte: white_gt ? CODE_WHITE : CODE_BLACK,
                        byte_kind: KIND_START};
        end else if (r_ovf) begin
            n_white = white_ge;
            n_run   = 8'd1;
            n_ovf   = 1'b0;
            n_emit  = 1'b1;
            n_code  = '{code_byte: (white_ge != r_white) ? CODE_CHANGE : CODE_NO_CHANGE,
                        byte_kind: KIND_OVERFLOW};
        end else if (white_ge != r_white) begin
            n_white = white_ge;
            n_run   = 8'd1;
            n_emit  = 1'b1;
            n_code  = '{code_byte: r_run, byte_kind: KIND_RUN};
        end else begin
            n_run = run_inc;
            n_ovf = (run_inc == RUN_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white   <= 1'b0;
            r_run     <= 8'd0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) begin
                r_white <= n_white;
                r_run   <= n_run;
                r_ovf   <= n_ovf;
            end
            if (o_item_ready) begin
                r_out_vld <= take && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && n_emit) begin
            r_out <= n_code;
        end
    end

`ifndef NO_ASSERTIONS
    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_run == RUN_LIMIT))
        else $error("overflow pending without a full run");

    a_run_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.byte_kind == KIND_RUN) |->
            (r_out.code_byte != 8'd0 && r_out.code_byte != RUN_LIMIT))
        else $error("run length outside 1 to 254");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.byte_kind == KIND_START || r_out.byte_kind == KIND_RUN
                       || r_out.byte_kind == KIND_OVERFLOW))
        else $error("illegal byte kind on output");

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && first) |=> (r_run == 8'd1 && !r_ovf))
        else $error("frame start did not open a run of one");
`endif

endmodule

FILE: sv/gray_threshold_run_length_encoder_unit.sv
// Top level of the gray threshold run-length encoder: APB register and glue.
// Depends on gtrle_pkg, gtrle_front, gtrle_queue and gtrle_back.
`timescale 1ns / 1ps

// Takes one BGR pixel per transaction and emits at most one code byte per pixel:
// a start colour on the first pixel of a frame, a run length on each colour
// change, or an overflow marker after a run of 255. The block sustains one
// pixel per clock; a code is presented after its pixel passes the gray
// register, one queue entry and the output register. The input stalls only
// when the receiver holds off long enough to fill the output register, the
// two-entry queue and the gray register. The threshold register sits at byte
// address 0 and should be written only while the block is idle.
module gray_threshold_run_length_encoder_unit import gtrle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pixel      i_in_pixel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_code       o_out_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_threshold;
    logic       reg_hit;
    logic       f_valid;
    logic       f_ready;
    t_gray_item f_item;
    logic       q_valid;
    logic       q_ready;
    t_gray_item q_item;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_THRESHOLD);
    assign prdata  = reg_hit ? {24'd0, r_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_threshold <= pwdata[7:0];
        end
    end

    gtrle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_pixel   (i_in_pixel),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    gtrle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    gtrle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_threshold  (r_threshold),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_code   (o_out_code)
    );

endmodule
